// ----- src/uint256_wrapping_alu_top_macros.svh -----
// Assertion macros for the 256-bit ALU checker
`ifndef UINT256_WRAPPING_ALU_TOP_MACROS_SVH
`define UINT256_WRAPPING_ALU_TOP_MACROS_SVH
`define U256_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define U256_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/u256alu_pkg.sv -----
// Package: beat types, action codes and constants for the 256-bit ALU
`timescale 1ns / 1ps
package u256alu_pkg;
  localparam int unsigned LIMBS = 8;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW = 2;
  localparam logic [31:0] LIMB_MASK = 32'hffffffff;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_CMP = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] a_w0;
    logic [63:0] a_w1;
    logic [63:0] a_w2;
    logic [63:0] a_w3;
    logic [63:0] b_w0;
    logic [63:0] b_w1;
    logic [63:0] b_w2;
    logic [63:0] b_w3;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] r_w0;
    logic [63:0] r_w1;
    logic [63:0] r_w2;
    logic [63:0] r_w3;
    logic        equal_flag;
    logic        fits_64;
    logic [31:0] fold32;
  } out_beat_t;

  // classified command handed from front to back
  typedef struct packed {
    action_t      action;
    logic [255:0] a;
    logic [255:0] b;
  } cmd_t;
endpackage

// ----- src/u256alu_front.sv -----
// Front end: accept beats, classify and push commands into a short queue
`timescale 1ns / 1ps
module u256alu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  u256alu_pkg::in_beat_t in_beat,
  output logic                busy,
  output logic                cmd_valid,
  output u256alu_pkg::cmd_t   cmd,
  input  logic                cmd_pop
);
  u256alu_pkg::cmd_t mem [u256alu_pkg::QDEPTH];
  logic [u256alu_pkg::QPTRW-1:0] wptr, rptr;
  logic [u256alu_pkg::QPTRW:0]   count;
  logic push;

  assign busy = (count == 3'(u256alu_pkg::QDEPTH));
  assign push = start && !busy;
  assign cmd_valid = (count != '0);
  assign cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{action: u256alu_pkg::action_t'(in_beat.action),
                     a: {in_beat.a_w3, in_beat.a_w2, in_beat.a_w1, in_beat.a_w0},
                     b: {in_beat.b_w3, in_beat.b_w2, in_beat.b_w1, in_beat.b_w0}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (cmd_pop) rptr <= rptr + 1'b1;
      count <= count + 3'(push) - 3'(cmd_pop);
    end
  end
endmodule

// ----- src/u256alu_back.sv -----
// Back end: pipelined add, subtract, multiply and compare with result flags
`timescale 1ns / 1ps
module u256alu_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  u256alu_pkg::cmd_t      cmd,
  output logic                   cmd_pop,
  output logic                   done,
  output u256alu_pkg::out_beat_t result
);
  // stage 1: 36 partial products of the low triangle, plus add/sub/eq
  logic [63:0]  pp [u256alu_pkg::LIMBS][u256alu_pkg::LIMBS];
  logic [255:0] s1_lin;
  logic         s1_eq;
  u256alu_pkg::action_t s1_act;
  logic         s1_v;
  // stage 2: column sums
  logic [35:0]  s2_col [u256alu_pkg::LIMBS];
  logic [255:0] s2_lin;
  logic         s2_eq;
  u256alu_pkg::action_t s2_act;
  logic         s2_v;
  logic [35:0]  col [u256alu_pkg::LIMBS];
  logic [255:0] prod_lo;
  logic [255:0] prod_hi;
  logic [255:0] r;
  logic [31:0]  fold;

  assign cmd_pop = cmd_valid;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (i + j < 8) begin
          pp[i][j] <= 64'(cmd.a[32*i +: 32]) * 64'(cmd.b[32*j +: 32]);
        end else begin
          pp[i][j] <= '0;
        end
      end
    end
    s1_lin <= (cmd.action == u256alu_pkg::ACT_SUB) ? cmd.a - cmd.b : cmd.a + cmd.b;
    s1_eq  <= (cmd.a == cmd.b);
    s1_act <= cmd.action;
  end

  // sum low halves into their own column and high halves into the next one
  always_comb begin
    for (int k = 0; k < 8; k++) col[k] = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (i + j < 8) begin
          col[i+j] = col[i+j] + 36'(pp[i][j][31:0]);
          if (i + j < 7) begin
            col[i+j+1] = col[i+j+1] + 36'(pp[i][j][63:32]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) s2_col[k] <= col[k];
    s2_lin <= s1_lin;
    s2_eq  <= s1_eq;
    s2_act <= s1_act;
  end

  // resolve column carries with one wide add
  always_comb begin
    prod_hi = '0;
    for (int k = 0; k < 8; k++) prod_lo[32*k +: 32] = s2_col[k][31:0];
    for (int k = 0; k < 7; k++) prod_hi[32*(k+1) +: 32] = 32'(s2_col[k][35:32]);
  end

  always_comb begin
    unique case (s2_act)
      u256alu_pkg::ACT_ADD, u256alu_pkg::ACT_SUB: r = s2_lin;
      u256alu_pkg::ACT_MUL: r = prod_lo + prod_hi;
      default: r = '0;
    endcase
    fold = '0;
    for (int k = 0; k < 8; k++) fold = fold ^ r[32*k +: 32];
  end

  always_ff @(posedge clk) begin
    result.r_w0 <= r[63:0];
    result.r_w1 <= r[127:64];
    result.r_w2 <= r[191:128];
    result.r_w3 <= r[255:192];
    result.equal_flag <= (s2_act == u256alu_pkg::ACT_CMP) && s2_eq;
    result.fits_64 <= (r[255:64] == '0);
    result.fold32 <= fold & u256alu_pkg::LIMB_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= cmd_pop;
      s2_v <= s1_v;
      done <= s2_v;
    end
  end
endmodule

// ----- src/uint256_wrapping_alu_top.sv -----
// Top level: 256-bit wrapping add/sub/mul/compare ALU
// The done strobe follows the accepting edge through the queue, products,
// column sum and output registers. Throughput: one beat per cycle; the back end
// drains one command per cycle so busy stays low in steady state.
// Reset: synchronous rst empties the queue and clears all strobes.
`timescale 1ns / 1ps
module uint256_wrapping_alu_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  u256alu_pkg::in_beat_t  in_beat,
  output logic                   busy,
  output logic                   done,
  output u256alu_pkg::out_beat_t result
);
  logic              cmd_valid;
  logic              cmd_pop;
  u256alu_pkg::cmd_t cmd;

  u256alu_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_beat(in_beat), .busy(busy),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  u256alu_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .done(done), .result(result)
  );
endmodule

// ----- src/u256alu_checker.sv -----
// Checker: port-level properties of the 256-bit ALU, bound to the top level
`timescale 1ns / 1ps
`include "uint256_wrapping_alu_top_macros.svh"
module u256alu_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input u256alu_pkg::out_beat_t result
);
  `U256_ASSERT_IMPL(a_eq_zero, clk, rst, done && result.equal_flag, (result.r_w0 == '0) && (result.r_w1 == '0))
  `U256_ASSERT_IMPL(a_fold, clk, rst, done && result.fits_64 && result.r_w0 == '0, result.fold32 == '0)
  `U256_ASSERT_NEXT(a_no_busy, clk, rst, !busy, !busy || $past(start))
  `U256_ASSERT_IMPL(a_done_src, clk, rst, done && !$past(rst, 3) && !$past(rst, 4), $past(start && !busy, 4))
endmodule

bind uint256_wrapping_alu_top u256alu_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

// ----- tb/uint256_wrapping_alu_top_tb.sv -----
// Testbench for the 256-bit wrapping ALU: table-driven and random beats checked against a predictor
`timescale 1ns / 1ps
module uint256_wrapping_alu_top_tb;
  localparam int RANDOM_BEATS = 1750;
  localparam int LATENCY = 4;

  logic clk;
  logic rst;
  logic start;
  u256alu_pkg::in_beat_t in_beat;
  logic busy;
  logic done;
  u256alu_pkg::out_beat_t result;

  u256alu_pkg::out_beat_t alu_results_q[$];
  int mismatches;
  int beats_sent;
  int results_seen;
  int idle_pct;

  uint256_wrapping_alu_top i_dut (
    .clk(clk), .rst(rst), .start(start), .in_beat(in_beat),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic u256alu_pkg::out_beat_t alu_compute(u256alu_pkg::in_beat_t b);
    u256alu_pkg::out_beat_t r;
    logic [255:0] x;
    logic [255:0] y;
    logic [255:0] z;
    logic [31:0] f;
    x = {b.a_w3, b.a_w2, b.a_w1, b.a_w0};
    y = {b.b_w3, b.b_w2, b.b_w1, b.b_w0};
    z = '0;
    r = '0;
    case (u256alu_pkg::action_t'(b.action))
      u256alu_pkg::ACT_ADD: z = x + y;
      u256alu_pkg::ACT_SUB: z = x - y;
      u256alu_pkg::ACT_MUL: z = x * y;
      default: r.equal_flag = (x == y);
    endcase
    f = '0;
    for (int i = 0; i < u256alu_pkg::LIMBS; i++) f ^= z[32*i +: 32];
    r.r_w0 = z[63:0];
    r.r_w1 = z[127:64];
    r.r_w2 = z[191:128];
    r.r_w3 = z[255:192];
    r.fits_64 = (z[255:64] == '0);
    r.fold32 = f;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %h want %h", results_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    u256alu_pkg::out_beat_t w;
    if (!rst && done) begin
      if (alu_results_q.size() == 0) begin
        report_mismatch("unexpected", 64'd0, 64'd0);
      end else begin
        w = alu_results_q.pop_front();
        if (result.r_w0 !== w.r_w0) report_mismatch("r_w0", result.r_w0, w.r_w0);
        if (result.r_w1 !== w.r_w1) report_mismatch("r_w1", result.r_w1, w.r_w1);
        if (result.r_w2 !== w.r_w2) report_mismatch("r_w2", result.r_w2, w.r_w2);
        if (result.r_w3 !== w.r_w3) report_mismatch("r_w3", result.r_w3, w.r_w3);
        if (result.equal_flag !== w.equal_flag)
          report_mismatch("equal_flag", 64'(result.equal_flag), 64'(w.equal_flag));
        if (result.fits_64 !== w.fits_64)
          report_mismatch("fits_64", 64'(result.fits_64), 64'(w.fits_64));
        if (result.fold32 !== w.fold32)
          report_mismatch("fold32", 64'(result.fold32), 64'(w.fold32));
      end
      results_seen++;
    end
  end

  // hold start until the beat is taken
  task automatic send_beat(u256alu_pkg::in_beat_t b, u256alu_pkg::out_beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    alu_results_q.push_back(want);
    beats_sent++;
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1;
      3: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic u256alu_pkg::in_beat_t make_beat(u256alu_pkg::action_t act,
                                                       logic [255:0] x, logic [255:0] y);
    u256alu_pkg::in_beat_t b;
    b.action = act;
    {b.a_w3, b.a_w2, b.a_w1, b.a_w0} = x;
    {b.b_w3, b.b_w2, b.b_w1, b.b_w0} = y;
    return b;
  endfunction

  typedef struct {
    u256alu_pkg::action_t act;
    logic [255:0] x;
    logic [255:0] y;
    logic known;
    logic [255:0] z;
    logic eq;
  } stim_row_t;

  localparam logic [255:0] ONES = '1;
  localparam logic [255:0] ONE = 256'd1;

  stim_row_t stim_table[] = '{
    '{u256alu_pkg::ACT_ADD, '0, '0, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_ADD, ONES, ONE, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_ADD, ONES, ONES, 1'b1, ONES - 1, 1'b0},
    '{u256alu_pkg::ACT_ADD, {192'd0, 64'hffffffffffffffff}, ONE, 1'b1,
      {191'd0, 1'b1, 64'd0}, 1'b0},
    '{u256alu_pkg::ACT_SUB, '0, ONE, 1'b1, ONES, 1'b0},
    '{u256alu_pkg::ACT_SUB, ONES, ONES, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_SUB, '0, ONES, 1'b1, ONE, 1'b0},
    '{u256alu_pkg::ACT_SUB, {192'd0, 64'hffffffffffffffff}, '0, 1'b1,
      {192'd0, 64'hffffffffffffffff}, 1'b0},
    '{u256alu_pkg::ACT_MUL, ONES, ONES, 1'b1, ONE, 1'b0},
    '{u256alu_pkg::ACT_MUL, ONES, '0, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_MUL, ONES, ONE, 1'b1, ONES, 1'b0},
    '{u256alu_pkg::ACT_MUL, {128'd0, 128'hffffffffffffffffffffffffffffffff},
      {128'd0, 128'hffffffffffffffffffffffffffffffff}, 1'b0, '0, 1'b0},
    '{u256alu_pkg::ACT_MUL, {192'd0, 64'hffffffffffffffff},
      {192'd0, 64'hffffffffffffffff}, 1'b0, '0, 1'b0},
    '{u256alu_pkg::ACT_MUL, 256'h1 << 255, 256'd2, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_MUL, {64'h0123456789abcdef, 64'hfedcba9876543210, 64'hffffffff00000000,
      64'h00000000ffffffff}, {64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
      64'hdeadbeefcafef00d, 64'hffffffffffffffff}, 1'b0, '0, 1'b0},
    '{u256alu_pkg::ACT_CMP, '0, '0, 1'b1, '0, 1'b1},
    '{u256alu_pkg::ACT_CMP, ONES, ONES, 1'b1, '0, 1'b1},
    '{u256alu_pkg::ACT_CMP, ONES, ONES - 1, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_CMP, '0, 256'h1 << 255, 1'b1, '0, 1'b0},
    '{u256alu_pkg::ACT_CMP, ONES, '0, 1'b1, '0, 1'b0}
  };

  initial begin
    u256alu_pkg::in_beat_t b;
    u256alu_pkg::out_beat_t w;
    logic [255:0] x;
    logic [255:0] y;
    logic [31:0] f;
    int timeout;
    rst <= 1'b1;
    start <= 1'b0;
    in_beat <= '0;
    mismatches = 0;
    beats_sent = 0;
    results_seen = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      b = make_beat(stim_table[i].act, stim_table[i].x, stim_table[i].y);
      if (stim_table[i].known) begin
        w = '0;
        f = '0;
        for (int k = 0; k < u256alu_pkg::LIMBS; k++) f ^= stim_table[i].z[32*k +: 32];
        {w.r_w3, w.r_w2, w.r_w1, w.r_w0} = stim_table[i].z;
        w.equal_flag = stim_table[i].eq;
        w.fits_64 = (stim_table[i].z[255:64] == '0);
        w.fold32 = f;
      end else begin
        w = alu_compute(b);
      end
      send_beat(b, w);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      case ((n * 4) / RANDOM_BEATS)
        0: idle_pct = 0;
        1: idle_pct = 76;
        2: idle_pct = 0;
        default: idle_pct = 35;
      endcase
      x = {rand_word(), rand_word(), rand_word(), rand_word()};
      y = {rand_word(), rand_word(), rand_word(), rand_word()};
      if ($urandom_range(3) == 0) y = x;
      else if ($urandom_range(7) == 0) y = x ^ (ONE << $urandom_range(255));
      b = make_beat(u256alu_pkg::action_t'($urandom_range(3)), x, y);
      send_beat(b, alu_compute(b));
    end
    start <= 1'b0;

    timeout = 0;
    while (alu_results_q.size() != 0 && timeout < 1000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d beats (add, sub, mul, compare) under four idling phases; %0d results.",
      beats_sent, results_seen);
    if (mismatches == 0 && alu_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
